// ===== rtl/rolling_hash_substring_search_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rolling hash substring search block
// ----------------------------------------------------------------------------
`ifndef ROLLING_HASH_SUBSTRING_SEARCH_MACROS_SVH
`define ROLLING_HASH_SUBSTRING_SEARCH_MACROS_SVH

// same-cycle implication, checked outside reset
`define RHSS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RHSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rhss_pkg.sv =====
// ----------------------------------------------------------------------------
// rhss_pkg
// Constants, types and control structs of the rolling hash substring search.
// ----------------------------------------------------------------------------
package rhss_pkg;

  // sizing
  localparam int PATTERN_MAX  = 64;
  localparam int TEXT_MAX     = 65536;
  localparam int HASH_MODULUS = 1000000;
  localparam int HASH_BASE    = 31;

  // derived widths
  localparam int PLW = $clog2(PATTERN_MAX + 1);                    // pattern length
  localparam int PIW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1; // history index
  localparam int TPW = $clog2(TEXT_MAX + 1);                       // text position
  localparam int CW  = ((TPW > PLW) ? TPW : PLW) + 1;              // position compares
  localparam int HW  = $clog2(HASH_MODULUS);                       // reduced hash
  localparam int RW  = HW + 8;                                     // unreduced value

  // restoring reduction: subtract modulus << 7 down to modulus << 0
  localparam int RED_STEPS = 8;
  localparam int RCW       = 3;

  typedef logic [7:0]    byte_t;
  typedef logic [15:0]   start_t;
  typedef logic [HW-1:0] hash_t;
  typedef logic [RW-1:0] red_t;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_NONE  = 2'd0,
    STATUS_MATCH = 2'd1,
    STATUS_POVF  = 2'd2,
    STATUS_TOVF  = 2'd3
  } status_t;

  // shift enables for the cell row
  typedef struct packed {
    logic shift_win;
    logic shift_pat;
  } cell_ctrl_t;

  // control of the modular reduction lanes
  typedef struct packed {
    logic           load;
    logic           step;
    logic [RCW-1:0] sh;
  } red_ctrl_t;

endpackage

// ===== rtl/rhss_if.sv =====
// ----------------------------------------------------------------------------
// rhss_if
// Valid/ready channels for byte input transactions and search results.
// ----------------------------------------------------------------------------
interface rhss_in_if import rhss_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   operation;
  byte_t byte_value;
  logic  last;

  modport source (output valid, output operation, output byte_value, output last,
                  input ready);
  modport sink   (input valid, input operation, input byte_value, input last,
                  output ready);
endinterface

interface rhss_out_if import rhss_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  start_t  match_start;

  modport source (output valid, output status, output match_start, input ready);
  modport sink   (input valid, input status, input match_start, output ready);
endinterface

// ===== rtl/rhss_cell.sv =====
// ----------------------------------------------------------------------------
// rhss_cell
// One position of the compare row: a window byte, a pattern byte, a match flag.
// ----------------------------------------------------------------------------
module rhss_cell import rhss_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  byte_t      win_in,
  input  byte_t      pat_in,
  input  logic       cmp_en,
  output byte_t      win_q,
  output byte_t      pat_q,
  output logic       match
);

  byte_t win_r;
  byte_t pat_r;
  logic  match_r;

  // shift toward the older end; positions past the pattern always match
  always_ff @(posedge clk) begin
    if (ctrl.shift_win) begin
      win_r <= win_in;
    end
    if (ctrl.shift_pat) begin
      pat_r <= pat_in;
    end
    match_r <= !cmp_en || (win_r == pat_r);
  end

  assign win_q = win_r;
  assign pat_q = pat_r;
  assign match = match_r;

endmodule

// ===== rtl/rhss_reduce.sv =====
// ----------------------------------------------------------------------------
// rhss_reduce
// Restoring modular reduction lane, one conditional subtract per cycle while step is set.
// ----------------------------------------------------------------------------
module rhss_reduce import rhss_pkg::*; (
  input  logic      clk,
  input  red_ctrl_t ctrl,
  input  red_t      load_val,
  output hash_t     result
);

  red_t val_r;
  red_t msh;

  // modulus scaled for the current step
  assign msh = RW'(HASH_MODULUS) << ctrl.sh;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      val_r <= load_val;
    end else if (ctrl.step && (val_r >= msh)) begin
      val_r <= val_r - msh;
    end
  end

  // below the modulus after the last step
  assign result = val_r[HW-1:0];

endmodule

// ===== rtl/rolling_hash_substring_search.sv =====
// ----------------------------------------------------------------------------
// rolling_hash_substring_search: Rabin-Karp search over a byte stream
// Pattern and text bytes each pass accept, multiply, 8 reduction steps and
// update in the shared reduction lanes; no byte is taken before the last is
// done. Overflowed pattern and text bytes skip the hash update; a last text
// byte adds an emit step, held while the previous result waits, which loads
// the registered result. Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`include "rolling_hash_substring_search_macros.svh"

module rolling_hash_substring_search import rhss_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  rhss_in_if.sink          in_chan,
  rhss_out_if.source       out_chan
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_RED  = 5'b00100,
    S_FIN  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  // control state
  state_t         state_r, state_nxt;
  logic [PLW-1:0] len_r, len_nxt;
  hash_t          ph_r, ph_nxt;
  hash_t          tp_r, tp_nxt;
  hash_t          wh_r, wh_nxt;
  logic [TPW-1:0] pos_r, pos_nxt;
  logic [PIW-1:0] wp_r, wp_nxt;
  logic           found_r, found_nxt;
  logic [TPW-1:0] fpos_r, fpos_nxt;
  logic           povf_r, povf_nxt;
  logic           tovf_r, tovf_nxt;
  logic           closed_r, closed_nxt;
  logic [RCW-1:0] cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;

  // per-transaction payload
  op_t            op_r;
  byte_t          byte_r;
  logic           last_r;
  logic [TPW-1:0] i_r;
  logic           use_old_r;
  byte_t          rd_r;
  status_t        out_status_r;
  start_t         out_start_r;

  byte_t          hist_mem [PATTERN_MAX];

  logic           in_acc;
  logic           out_load;
  logic [PLW-1:0] len_eff;
  logic [PLW-1:0] raddr_w;
  logic [PIW-1:0] raddr;
  cell_ctrl_t     cell_ctrl;
  red_ctrl_t      red_ctrl;
  red_t           x_load;
  red_t           y_load;
  byte_t          mul_a;
  hash_t          hsrc;
  hash_t          x_res;
  hash_t          y_res;
  hash_t          nh;
  logic           hit;
  logic           all_match;
  status_t        status_c;

  byte_t          win_q   [PATTERN_MAX];
  byte_t          pat_q   [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cmp_en;
  logic [PATTERN_MAX-1:0] cell_match;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  // a pattern byte after a closed pattern starts over
  assign len_eff = closed_r ? '0 : len_r;

  // history slot of the byte leaving the window: (wp - m) mod PATTERN_MAX
  assign raddr_w = (PLW'(wp_r) >= len_r) ? (PLW'(wp_r) - len_r)
                                        : (PLW'(wp_r) + PLW'(PATTERN_MAX) - len_r);
  assign raddr   = raddr_w[PIW-1:0];

  // compare row
  genvar g;
  generate
    for (g = 0; g < PATTERN_MAX; g++) begin : g_cell
      byte_t win_in;
      byte_t pat_in;
      if (g == 0) begin : g_head
        assign win_in = in_chan.byte_value;
        assign pat_in = in_chan.byte_value;
      end else begin : g_body
        assign win_in = win_q[g-1];
        assign pat_in = pat_q[g-1];
      end
      assign cmp_en[g] = (PLW'(g) < len_r);
      rhss_cell u_cell (
        .clk    (clk),
        .ctrl   (cell_ctrl),
        .win_in (win_in),
        .pat_in (pat_in),
        .cmp_en (cmp_en[g]),
        .win_q  (win_q[g]),
        .pat_q  (pat_q[g]),
        .match  (cell_match[g])
      );
    end
  endgenerate

  assign all_match = &cell_match;

  // lane operands: hash * 31 + byte, and leaving byte * 31^m (or 31^m * 31)
  assign hsrc   = (op_r == OP_TEXT) ? wh_r : ph_r;
  assign mul_a  = (op_r == OP_TEXT) ? (use_old_r ? rd_r : '0) : 8'(HASH_BASE);
  assign x_load = RW'(hsrc) * RW'(HASH_BASE) + RW'(byte_r);
  assign y_load = RW'(mul_a) * RW'(tp_r);

  rhss_reduce u_red_x (
    .clk      (clk),
    .ctrl     (red_ctrl),
    .load_val (x_load),
    .result   (x_res)
  );

  rhss_reduce u_red_y (
    .clk      (clk),
    .ctrl     (red_ctrl),
    .load_val (y_load),
    .result   (y_res)
  );

  // rolling window hash after removing the leaving byte
  assign nh = (x_res >= y_res) ? (x_res - y_res)
                               : HW'(RW'(x_res) + RW'(HASH_MODULUS) - RW'(y_res));

  assign hit = (len_r != '0) && !found_r && (CW'(i_r) + CW'(1) >= CW'(len_r)) &&
               (nh == ph_r) && all_match;

  // result status, pattern overflow first
  always_comb begin
    if (povf_r) begin
      status_c = STATUS_POVF;
    end else if (tovf_r) begin
      status_c = STATUS_TOVF;
    end else if (found_r && (len_r != '0)) begin
      status_c = STATUS_MATCH;
    end else begin
      status_c = STATUS_NONE;
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    ph_nxt      = ph_r;
    tp_nxt      = tp_r;
    wh_nxt      = wh_r;
    pos_nxt     = pos_r;
    wp_nxt      = wp_r;
    found_nxt   = found_r;
    fpos_nxt    = fpos_r;
    povf_nxt    = povf_r;
    tovf_nxt    = tovf_r;
    closed_nxt  = closed_r;
    cnt_nxt     = cnt_r;
    out_load    = 1'b0;
    cell_ctrl   = '0;
    red_ctrl    = '0;
    red_ctrl.sh = RCW'(RED_STEPS - 1) - cnt_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_chan.operation == OP_PATTERN) begin
            if (closed_r) begin
              ph_nxt   = '0;
              tp_nxt   = HW'(1);
              povf_nxt = 1'b0;
            end
            closed_nxt = in_chan.last;
            if (len_eff < PLW'(PATTERN_MAX)) begin
              len_nxt             = len_eff + PLW'(1);
              cell_ctrl.shift_pat = 1'b1;
              state_nxt           = S_MUL;
            end else begin
              len_nxt  = len_eff;
              povf_nxt = 1'b1;
            end
          end else begin
            if (CW'(pos_r) >= CW'(TEXT_MAX)) begin
              tovf_nxt = 1'b1;
              if (in_chan.last) begin
                state_nxt = S_EMIT;
              end
            end else begin
              pos_nxt             = pos_r + TPW'(1);
              wp_nxt              = (wp_r == PIW'(PATTERN_MAX - 1)) ? '0 : wp_r + PIW'(1);
              cell_ctrl.shift_win = 1'b1;
              state_nxt           = S_MUL;
            end
          end
        end
      end
      S_MUL: begin
        red_ctrl.load = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_RED;
      end
      S_RED: begin
        red_ctrl.step = 1'b1;
        cnt_nxt       = cnt_r + RCW'(1);
        if (cnt_r == RCW'(RED_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (op_r == OP_TEXT) begin
          wh_nxt = nh;
          if (hit) begin
            found_nxt = 1'b1;
            fpos_nxt  = TPW'(CW'(i_r) + CW'(1) - CW'(len_r));
          end
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end else begin
          ph_nxt    = x_res;
          tp_nxt    = y_res;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          pos_nxt   = '0;
          wp_nxt    = '0;
          wh_nxt    = '0;
          found_nxt = 1'b0;
          fpos_nxt  = '0;
          tovf_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      ph_r        <= '0;
      tp_r        <= HW'(1);
      wh_r        <= '0;
      pos_r       <= '0;
      wp_r        <= '0;
      found_r     <= 1'b0;
      fpos_r      <= '0;
      povf_r      <= 1'b0;
      tovf_r      <= 1'b0;
      closed_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      ph_r        <= ph_nxt;
      tp_r        <= tp_nxt;
      wh_r        <= wh_nxt;
      pos_r       <= pos_nxt;
      wp_r        <= wp_nxt;
      found_r     <= found_nxt;
      fpos_r      <= fpos_nxt;
      povf_r      <= povf_nxt;
      tovf_r      <= tovf_nxt;
      closed_r    <= closed_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // transaction payload capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_chan.operation;
      byte_r    <= in_chan.byte_value;
      last_r    <= in_chan.last;
      i_r       <= pos_r;
      use_old_r <= (len_r != '0) && (CW'(pos_r) >= CW'(len_r));
    end
    if (out_load) begin
      out_status_r <= status_c;
      out_start_r  <= (status_c == STATUS_MATCH) ? 16'(fpos_r) : '0;
    end
  end

  // window history: read the leaving byte before the slot is overwritten
  always_ff @(posedge clk) begin
    if (cell_ctrl.shift_win) begin
      rd_r            <= hist_mem[raddr];
      hist_mem[wp_r]  <= in_chan.byte_value;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.match_start = out_start_r;

  // checks
  `RHSS_ASSERT_NEXT(a_text_enters_mul, clk, rst_n,
    in_acc && (in_chan.operation == OP_TEXT) && (CW'(pos_r) < CW'(TEXT_MAX)),
    state_r == S_MUL, "text transaction did not start the hash update")
  `RHSS_ASSERT_NOW(a_hash_in_range, clk, rst_n, 1'b1,
    (RW'(wh_r) < RW'(HASH_MODULUS)) && (RW'(ph_r) < RW'(HASH_MODULUS)) &&
    (RW'(tp_r) < RW'(HASH_MODULUS)), "hash state not reduced below modulus")
  `RHSS_ASSERT_NEXT(a_result_from_emit, clk, rst_n,
    (state_r != S_EMIT) && !out_valid_r, !out_valid_r,
    "result raised outside the emit step")

endmodule
